/* rtl/hblpg_pkg.sv */
// Package for the heartbeat LED pattern generator.
// Holds the configuration and state types, timing constants and register indexes.
// No dependencies; the configuration, core and top files import it.
package hblpg_pkg;

  localparam int unsigned ElapsedW   = 11;
  localparam int unsigned LevelW     = 3;
  localparam int unsigned BurstCntW  = 2;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned DataW      = 32;

  typedef logic [ElapsedW-1:0]  elapsed_t;
  typedef logic [LevelW-1:0]    level_t;
  typedef logic [BurstCntW-1:0] burst_cnt_t;

  localparam elapsed_t   ELAPSED_MAX  = elapsed_t'(2047);
  localparam elapsed_t   BURST_STEP   = elapsed_t'(150);
  localparam elapsed_t   STANDBY_GAP  = elapsed_t'(1400);
  localparam burst_cnt_t BURST_LAST   = burst_cnt_t'(3);
  localparam level_t     LEVEL_STANDBY = level_t'(4);

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_LEVEL       = 2'd0,
    REG_ACTIVE_HIGH = 2'd1,
    REG_ENABLED     = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // Configuration handed from the register block to the pattern core
  typedef struct packed {
    level_t level;
    logic   active_high;
    logic   enabled;
    logic   level_wr;     // high in the cycle whose edge writes the level
  } cfg_t;

  // Toggle interval for the periodic levels 0 to 3
  function automatic elapsed_t interval_ms(input logic [1:0] lvl);
    elapsed_t iv;
    unique case (lvl)
      2'd0:    iv = elapsed_t'(125);
      2'd1:    iv = elapsed_t'(250);
      2'd2:    iv = elapsed_t'(500);
      default: iv = elapsed_t'(1000);
    endcase
    return iv;
  endfunction

endpackage

/* rtl/hblpg_if.sv */
// Valid/ready channel interfaces for tick beats and result beats.
// Depends on nothing; payload fields are single bits.
interface hblpg_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface hblpg_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic lamp_state;
  logic in_burst;
  modport source (output valid, output pin_level, output lamp_state, output in_burst,
                  input ready);
  modport sink   (input valid, input pin_level, input lamp_state, input in_burst,
                  output ready);
endinterface

/* rtl/hblpg_cfg.sv */
// APB-style configuration registers for the heartbeat generator.
// Depends on hblpg_pkg; drives the cfg_t bundle to the pattern core.
module hblpg_cfg
  import hblpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  output cfg_t                cfg
);

  level_t   level_r;
  logic     active_high_r;
  logic     enabled_r;
  logic     level_wr;
  logic     wr_en;
  reg_idx_t idx;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign idx      = reg_idx_t'(paddr[AddrW-1:2]);
  assign level_wr = wr_en & (idx == REG_LEVEL);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= '0;
      active_high_r <= 1'b1;
      enabled_r     <= 1'b1;
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_LEVEL:       level_r       <= pwdata[LevelW-1:0];
          REG_ACTIVE_HIGH: active_high_r <= pwdata[0];
          REG_ENABLED:     enabled_r     <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_LEVEL:       prdata = DataW'(level_r);
      REG_ACTIVE_HIGH: prdata = DataW'(active_high_r);
      REG_ENABLED:     prdata = DataW'(enabled_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{level: level_r, active_high: active_high_r,
                 enabled: enabled_r, level_wr: level_wr};

endmodule

/* rtl/hblpg_core.sv */
// Pattern state update and result register of the heartbeat generator.
// Depends on hblpg_pkg and the channel interfaces in hblpg_if.sv.
module hblpg_core
  import hblpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  hblpg_in_if.sink          in_ch,
  hblpg_out_if.source       out_ch
);

  elapsed_t   elapsed_r, elapsed_nxt, elapsed_inc;
  logic       toggle_r, toggle_nxt;
  logic       burst_r, burst_nxt;
  burst_cnt_t bcnt_r, bcnt_nxt;

  logic out_valid_r;
  logic pin_r, lamp_r, burst_out_r;
  logic accept, advance, eff;

  // Take a beat whenever the result register is free or being drained
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;
  assign advance     = accept & in_ch.tick & cfg.enabled;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  // Next pattern state for one tick
  always_comb begin
    elapsed_nxt = elapsed_r;
    toggle_nxt  = toggle_r;
    burst_nxt   = burst_r;
    bcnt_nxt    = bcnt_r;
    if (advance) begin
      elapsed_nxt = elapsed_inc;
      if (!cfg.level[LevelW-1]) begin
        if (elapsed_inc >= interval_ms(cfg.level[1:0])) begin
          toggle_nxt  = ~toggle_r;
          elapsed_nxt = '0;
        end
      end else if (cfg.level == LEVEL_STANDBY) begin
        priority if (burst_r) begin
          if (elapsed_inc >= BURST_STEP) begin
            toggle_nxt  = ~toggle_r;
            elapsed_nxt = '0;
            if (bcnt_r == BURST_LAST) begin
              burst_nxt = 1'b0;
              bcnt_nxt  = '0;
            end else begin
              bcnt_nxt = bcnt_r + 1'b1;
            end
          end
        end else if (elapsed_inc >= STANDBY_GAP) begin
          burst_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
      end
    end
    // A level write restarts the interval
    if (cfg.level_wr) begin
      elapsed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      toggle_r  <= 1'b0;
      burst_r   <= 1'b0;
      bcnt_r    <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      toggle_r  <= toggle_nxt;
      burst_r   <= burst_nxt;
      bcnt_r    <= bcnt_nxt;
    end
  end

  // Standby inverts the lamp sense, polarity picks the pin level
  assign eff = toggle_nxt ^ (cfg.level == LEVEL_STANDBY);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_r       <= cfg.active_high ? eff : ~eff;
      lamp_r      <= toggle_nxt;
      burst_out_r <= burst_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pin_level  = pin_r;
  assign out_ch.lamp_state = lamp_r;
  assign out_ch.in_burst   = burst_out_r;

endmodule

/* rtl/heartbeat_led_pattern_generator.sv */
// Top level of the heartbeat LED pattern generator.
// Depends on hblpg_pkg, hblpg_if.sv, hblpg_cfg and hblpg_core.
//
// Usage:
//   in_ch carries one tick beat per sample: tick=1 means one millisecond has
//   passed, tick=0 only samples the current output. out_ch returns exactly one
//   result beat (pin_level, lamp_state, in_burst) per accepted tick beat, in order.
//   The APB port holds three registers: level at 0x0, active_high at 0x4 and
//   enabled at 0x8. Writes land on the access cycle; pready is tied high.
//   Latency: a result is valid the cycle after its tick beat is accepted.
//   Throughput: one beat per cycle unless stalled; the pattern update is a single
//   increment and compare between the state registers and the result register.
//   Stall: while out_ch.ready is low the result register holds its beat and
//   in_ch.ready drops once that register is full; nothing is lost or repeated.
//   Reset (synchronous, rst_n low): lamp off, in pause, elapsed count zero,
//   level 0, active high, enabled; the result register is emptied.
//   Configure only while no beat is in flight.
module heartbeat_led_pattern_generator
  import hblpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  hblpg_in_if.sink         in_ch,
  hblpg_out_if.source      out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  hblpg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hblpg_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
